// ----- rtl/core/glyph_row_rasterizer_top_defines.svh -----
// assertion macros used by the rasteriser controller
`ifndef GLYPH_ROW_RASTERIZER_TOP_DEFINES_SVH
`define GLYPH_ROW_RASTERIZER_TOP_DEFINES_SVH
// clocked implication check
`define GRR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication check
`define GRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/grr_pkg.sv -----
// shared types and constants of the glyph row rasteriser
package grr_pkg;
  localparam int unsigned GlyphEntries = 256;
  localparam int unsigned BitmapBytes  = 4096;
  localparam int unsigned MaxGlyphSide = 32;

  localparam logic [1:0] KindSetPen   = 2'd0;
  localparam logic [1:0] KindDraw     = 2'd1;
  localparam logic [1:0] KindGlyph    = 2'd2;
  localparam logic [1:0] KindByte     = 2'd3;

  localparam logic [2:0] RegFirstCode = 3'd0;
  localparam logic [2:0] RegLastCode  = 3'd1;
  localparam logic [2:0] RegBandLeft  = 3'd2;
  localparam logic [2:0] RegBandTop   = 3'd3;
  localparam logic [2:0] RegBandWidth = 3'd4;
  localparam logic [2:0] RegBandHght  = 3'd5;
  localparam logic [2:0] RegColour    = 3'd6;
  localparam logic [2:0] RegAlpha     = 3'd7;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         char_code;
    logic signed [11:0] pen_x;
    logic signed [11:0] pen_y;
    logic [11:0]        address;
    logic [7:0]         byte_value;
    logic [11:0]        bitmap_start;
    logic [5:0]         glyph_cols;
    logic [5:0]         glyph_rows;
    logic [7:0]         advance;
    logic signed [7:0]  offset_x;
    logic signed [7:0]  offset_y;
  } item_t;

  typedef struct packed {
    logic [10:0]        screen_row;
    logic signed [11:0] start_column;
    logic [31:0]        pixel_mask;
    logic [15:0]        colour_out;
    logic [8:0]         coverage;
    logic               last_row;
  } result_t;

  // glyph entry as stored: start, cols, rows, advance, offsets
  typedef struct packed {
    logic [11:0]       start;
    logic [5:0]        cols;
    logic [5:0]        rows;
    logic [7:0]        adv;
    logic signed [7:0] offx;
    logic signed [7:0] offy;
  } glyph_t;

  // controller to datapath
  typedef struct packed {
    logic cap_item;   // register the transaction
    logic glyph_rd;   // write glyph table or bitmap store
    logic setup;      // latch glyph, compute row geometry
    logic take_byte;  // shift read byte into row buffer
    logic row_done;   // advance to next row
    logic emit;       // present the row result
    logic advance;    // move the pen
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] kind;
    logic       in_font;
    logic       no_rows;
    logic       row_visible;
    logic       row_bytes_left;
    logic       last_glyph_row;
  } stat_t;
endpackage

// ----- rtl/core/glyph_row_rasterizer_top.sv -----
// glyph row rasteriser: one character item in, one result per visible glyph row out
// sequence: set-pen, glyph-table and byte-store writes pass through the decode state; a character
// passes decode, lookup and setup, then per glyph row a fetch state, a row state and, in a visible
// row, a fetch and gather pair per bitmap byte touched; a glyph with no rows ends after its fetch
// state; byte fetches share the single bitmap port and a new item is taken only when idle; results
// are registered from the row state and cannot be stalled; reset restores register defaults and
// clears the pen, and the glyph and bitmap stores are not cleared
module glyph_row_rasterizer_top #(
  parameter int unsigned GlyphEntries = grr_pkg::GlyphEntries,
  parameter int unsigned BitmapBytes  = grr_pkg::BitmapBytes,
  parameter int unsigned MaxGlyphSide = grr_pkg::MaxGlyphSide
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  grr_pkg::item_t   item_i,
  output logic             result_valid_o,
  output grr_pkg::result_t result_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i
);
  grr_pkg::ctrl_t ctrl;
  grr_pkg::stat_t stat;

  grr_ctrl u_ctrl (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (start), .busy_o (busy),
    .stat_i (stat), .ctrl_o (ctrl), .valid_o (result_valid_o)
  );

  grr_datapath #(
    .GlyphEntries (GlyphEntries), .BitmapBytes (BitmapBytes), .MaxGlyphSide (MaxGlyphSide)
  ) u_dp (
    .clk_i (clk_i), .rst_ni (rst_ni), .item_i (item_i),
    .cfg_we_i (cfg_we_i), .cfg_index_i (cfg_index_i), .cfg_data_i (cfg_data_i),
    .ctrl_i (ctrl), .stat_o (stat), .result_o (result_o)
  );
endmodule

// ----- rtl/core/grr_ram.sv -----
// generic single-port write, registered-read ram
module grr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/core/grr_datapath.sv -----
// datapath: registers, stores, row walker and clipping
module grr_datapath #(
  parameter int unsigned GlyphEntries = grr_pkg::GlyphEntries,
  parameter int unsigned BitmapBytes  = grr_pkg::BitmapBytes,
  parameter int unsigned MaxGlyphSide = grr_pkg::MaxGlyphSide
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  grr_pkg::item_t  item_i,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_index_i,
  input  logic [15:0]     cfg_data_i,
  input  grr_pkg::ctrl_t  ctrl_i,
  output grr_pkg::stat_t  stat_o,
  output grr_pkg::result_t result_o
);
  localparam int unsigned GAw = (GlyphEntries > 1) ? $clog2(GlyphEntries) : 1;
  localparam int unsigned BAw = $clog2(BitmapBytes);
  localparam int unsigned SideCap = (MaxGlyphSide < 32) ? MaxGlyphSide : 32;
  localparam logic [5:0] SideCapW = 6'(SideCap);

  logic [7:0]  first_q, last_q, alpha_q;
  logic [9:0]  left_q, top_q;
  logic [10:0] bw_q, bh_q;
  logic [15:0] colour_q;
  logic signed [11:0] pen_col_q, base_q;
  grr_pkg::item_t item_q;
  grr_pkg::glyph_t g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 8'd32; last_q <= 8'd126; left_q <= '0; top_q <= '0;
      bw_q <= 11'd320; bh_q <= 11'd16; colour_q <= 16'hffff; alpha_q <= 8'd255;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        grr_pkg::RegFirstCode: first_q  <= cfg_data_i[7:0];
        grr_pkg::RegLastCode:  last_q   <= cfg_data_i[7:0];
        grr_pkg::RegBandLeft:  left_q   <= cfg_data_i[9:0];
        grr_pkg::RegBandTop:   top_q    <= cfg_data_i[9:0];
        grr_pkg::RegBandWidth: bw_q     <= cfg_data_i[10:0];
        grr_pkg::RegBandHght:  bh_q     <= cfg_data_i[10:0];
        grr_pkg::RegColour:    colour_q <= cfg_data_i;
        grr_pkg::RegAlpha:     alpha_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap_item) item_q <= item_i;
  end

  // glyph table
  logic [5:0] cols_cap, rows_cap;
  grr_pkg::glyph_t g_wr, g_rd;
  logic [8:0] idx_w;
  logic [GAw-1:0] g_raddr;
  assign cols_cap = (item_q.glyph_cols > SideCapW) ? SideCapW : item_q.glyph_cols;
  assign rows_cap = (item_q.glyph_rows > SideCapW) ? SideCapW : item_q.glyph_rows;
  assign g_wr = '{start: item_q.bitmap_start, cols: cols_cap, rows: rows_cap,
                  adv: item_q.advance, offx: item_q.offset_x, offy: item_q.offset_y};
  assign idx_w = {1'b0, item_q.char_code} - {1'b0, first_q};
  assign g_raddr = GAw'(idx_w);

  grr_ram #(.Width($bits(grr_pkg::glyph_t)), .Depth(GlyphEntries)) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.glyph_rd && item_q.kind == grr_pkg::KindGlyph),
    .waddr_i (GAw'(item_q.address % GlyphEntries)),
    .wdata_i (g_wr),
    .raddr_i (g_raddr),
    .rdata_o (g_rd)
  );

  // bitmap store
  logic [BAw-1:0] bit_byte_q;  // byte address of bit cursor
  logic [2:0]     bit_off_q;
  logic [7:0]     byte_rd;
  grr_ram #(.Width(8), .Depth(BitmapBytes)) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.glyph_rd && item_q.kind == grr_pkg::KindByte),
    .waddr_i (BAw'(item_q.address % BitmapBytes)),
    .wdata_i (item_q.byte_value),
    .raddr_i (bit_byte_q),
    .rdata_o (byte_rd)
  );

  // row walker
  logic signed [12:0] gx_q, y_q;
  logic [5:0]  row_q;
  logic [5:0]  col_q;     // columns of this row gathered so far
  logic [31:0] rowbits_q; // glyph column i at bit i
  logic signed [12:0] left_s, right_s, top_s, bottom_s;
  assign left_s   = 13'(left_q);
  assign right_s  = 13'(left_q) + 13'(bw_q);
  assign top_s    = 13'(top_q);
  assign bottom_s = 13'(top_q) + 13'(bh_q);

  logic row_vis;
  assign row_vis = (alpha_q != 8'd0) && (y_q >= top_s) && (y_q < bottom_s);

  // bits available in the fetched byte from the current offset
  logic [3:0] avail, need, take;
  assign avail = 4'd8 - 4'(bit_off_q);
  assign need  = 4'(g_q.cols - col_q > 6'd8 ? 6'd8 : g_q.cols - col_q);
  assign take  = (need < avail) ? need : avail;

  logic [7:0]  aligned;
  logic [31:0] new_bits;
  assign aligned = byte_rd << bit_off_q;
  always_comb begin
    new_bits = '0;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < take) new_bits[k] = aligned[7-k];
    end
  end

  // skip a whole row: advance cursor by cols
  logic [BAw+2:0] cur_bits, skip_bits, step_bits;
  assign cur_bits  = {bit_byte_q, bit_off_q};
  assign skip_bits = cur_bits + (BAw+3)'(g_q.cols);
  assign step_bits = cur_bits + (BAw+3)'(take);

  logic signed [12:0] gx_c, gy_c;
  assign gx_c = 13'(pen_col_q) + 13'(g_rd.offx);
  assign gy_c = 13'(base_q) + 13'(g_rd.offy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_col_q <= '0; base_q <= '0;
    end else begin
      if (ctrl_i.cap_item && item_i.kind == grr_pkg::KindSetPen) begin
        pen_col_q <= item_i.pen_x; base_q <= item_i.pen_y;
      end
      if (ctrl_i.advance) pen_col_q <= pen_col_q + 12'(g_q.adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.setup) begin
      g_q <= g_rd;
      gx_q <= gx_c; y_q <= gy_c;
      row_q <= '0; col_q <= '0; rowbits_q <= '0;
      {bit_byte_q, bit_off_q} <= (BAw+3)'({g_rd.start, 3'b000});
    end else begin
      if (ctrl_i.take_byte) begin
        rowbits_q <= rowbits_q | (new_bits << col_q);
        col_q <= col_q + 6'(take);
        {bit_byte_q, bit_off_q} <= step_bits;
      end
      if (ctrl_i.row_done) begin
        if (!row_vis) {bit_byte_q, bit_off_q} <= skip_bits;
        row_q <= row_q + 6'd1; y_q <= y_q + 13'sd1;
        col_q <= '0; rowbits_q <= '0;
      end
    end
  end

  // later rows visible? rows are contiguous so check the next row
  logic signed [12:0] y_next;
  assign y_next = y_q + 13'sd1;

  // clip mask
  logic [31:0] clip;
  always_comb begin
    for (int k = 0; k < 32; k++) begin
      clip[k] = ((gx_q + 13'(k)) >= left_s) && ((gx_q + 13'(k)) < right_s);
    end
  end

  logic signed [12:0] sc;
  logic signed [11:0] sc_sat;
  assign sc = gx_q - left_s;
  assign sc_sat = (sc < -13'sd2048) ? 12'sh800 : (sc > 13'sd2047) ? 12'sh7ff : sc[11:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_o <= '0;
    end else if (ctrl_i.emit) begin
      result_o.screen_row   <= y_q[10:0];
      result_o.start_column <= sc_sat;
      result_o.pixel_mask   <= rowbits_q & clip;
      result_o.colour_out   <= colour_q;
      result_o.coverage     <= {1'b0, alpha_q} + 9'(alpha_q[7]);
      result_o.last_row     <= (row_q + 6'd1 == g_q.rows) ||
                               !((alpha_q != 8'd0) && y_next >= top_s && y_next < bottom_s);
    end
  end

  assign stat_o.kind           = item_q.kind;
  assign stat_o.in_font        = (item_q.char_code >= first_q) && (item_q.char_code <= last_q)
                                 && (idx_w < 9'(GlyphEntries));
  assign stat_o.no_rows        = (g_q.rows == 6'd0);
  assign stat_o.row_visible    = row_vis;
  assign stat_o.row_bytes_left = (col_q < g_q.cols);
  assign stat_o.last_glyph_row = (row_q + 6'd1 >= g_q.rows);
endmodule

// ----- rtl/core/grr_ctrl.sv -----
// controller: sequences glyph lookup, byte fetches and row output
module grr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  grr_pkg::stat_t stat_i,
  output grr_pkg::ctrl_t ctrl_o,
  output logic           valid_o
);
  typedef enum logic [2:0] {
    StIdle, StDecode, StLookup, StSetup, StFetch, StGather, StRow, StEmit
  } state_e;

  state_e state_q;
  logic   valid_q;

  always_comb begin
    ctrl_o = '0;
    ctrl_o.cap_item = start_i && (state_q == StIdle);
    case (state_q)
      StDecode: ctrl_o.glyph_rd = 1'b1;
      StSetup:  ctrl_o.setup    = 1'b1;
      // a glyph with no rows still moves the pen
      StFetch:  ctrl_o.advance  = stat_i.no_rows;
      StGather: ctrl_o.take_byte = 1'b1;
      StRow: begin
        ctrl_o.row_done = 1'b1;
        ctrl_o.emit     = stat_i.row_visible;
        ctrl_o.advance  = stat_i.last_glyph_row;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_o.emit;
      case (state_q)
        StIdle: if (start_i) state_q <= StDecode;
        StDecode: begin
          if (stat_i.kind == grr_pkg::KindDraw && stat_i.in_font) state_q <= StLookup;
          else state_q <= StIdle;
        end
        StLookup: state_q <= StSetup;
        StSetup:  state_q <= StFetch;
        StFetch: begin
          if (stat_i.no_rows) state_q <= StIdle;
          else if (stat_i.row_visible && stat_i.row_bytes_left) state_q <= StGather;
          else state_q <= StRow;
        end
        StGather: state_q <= StFetch;
        StRow: begin
          if (stat_i.last_glyph_row) state_q <= StIdle;
          else state_q <= StFetch;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o  = (state_q != StIdle);
  assign valid_o = valid_q;

  `include "glyph_row_rasterizer_top_defines.svh"
  `GRR_ASSERT_IMP(a_emit_in_row, clk_i, rst_ni, ctrl_o.emit, state_q == StRow)
  `GRR_ASSERT_NEXT(a_valid_follows, clk_i, rst_ni, ctrl_o.emit, valid_q)
  `GRR_ASSERT_IMP(a_take_not_idle, clk_i, rst_ni, ctrl_o.take_byte, busy_o)
endmodule
